### rtl/swrc_pkg.sv
// package: codes, reset values and word types of the stop-and-wait retry controller
`timescale 1ns / 1ps
`default_nettype none
package swrc_pkg;

  localparam logic [7:0]  MAX_PAYLOAD_DEF = 8'd240;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
  localparam logic [7:0]  RETRY_RST       = 8'd3;
  localparam logic [7:0]  NEXT_ID_RST     = 8'd1;
  localparam int          QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_RX   = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RX_DATA    = 2'd0,
    RX_ACK     = 2'd1,
    RX_NACK    = 2'd2,
    RX_UNKNOWN = 2'd3
  } rx_kind_t;

  typedef enum logic [2:0] {
    K_TX_DATA = 3'd0,
    K_TX_ACK  = 3'd1,
    K_DELIVER = 3'd2,
    K_SUCCESS = 3'd3,
    K_FAILED  = 3'd4,
    K_TIMEOUT = 3'd5,
    K_REJECT  = 3'd6
  } kind_t;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_RETRY   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    B_EMPTY  = 2'd0,
    B_FIRST  = 2'd1,
    B_SECOND = 2'd2
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  msg_id;
    logic [7:0]  attempt;
  } res_t;

  typedef struct packed {
    logic [31:0] sent;
    logic [31:0] timeouts;
    logic [31:0] retries;
    logic [31:0] acks;
  } stats_t;

  // one queued entry: the one or two results of an input item
  typedef struct packed {
    res_t   r0;
    res_t   r1;
    logic   two;
    logic   pending;
    stats_t stats;
  } entry_t;

endpackage
`default_nettype wire

### rtl/swrc_front.sv
// front part: protocol state, statistics and classification of input words
`timescale 1ns / 1ps
`default_nettype none
module swrc_front #(
  parameter logic [7:0] MAX_PAYLOAD = swrc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic [1:0]       in_func,
  input  wire logic [7:0]       in_payload_len,
  input  wire logic [1:0]       in_rx_kind,
  input  wire logic [7:0]       in_rx_id,
  input  wire logic             in_rx_frame_ok,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data,
  output logic                  push,
  output swrc_pkg::entry_t      push_entry
);

  logic [15:0] timeout_ticks_r;
  logic [7:0]  retry_limit_r;
  logic [7:0]  next_id_r, next_id_nxt;
  logic        waiting_r, waiting_nxt;
  logic [7:0]  pending_id_r, pending_id_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  swrc_pkg::stats_t stats_r, stats_nxt;

  logic [1:0]       n_res;
  swrc_pkg::res_t   r0, r1;
  swrc_pkg::res_t   rf_res;
  logic             rf_fail;
  logic [15:0]      elapsed_inc;
  logic             match;
  logic             accept;

  assign accept = in_valid && in_ready;
  assign match  = waiting_r && (in_rx_id == pending_id_r);

  // retransmit or give up
  assign rf_fail     = retries_r >= retry_limit_r;
  assign rf_res.kind = rf_fail ? swrc_pkg::K_FAILED : swrc_pkg::K_TX_DATA;
  assign rf_res.msg_id  = pending_id_r;
  assign rf_res.attempt = rf_fail ? retries_r : retries_r + 8'd1;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    next_id_nxt    = next_id_r;
    waiting_nxt    = waiting_r;
    pending_id_nxt = pending_id_r;
    retries_nxt    = retries_r;
    elapsed_nxt    = elapsed_r;
    stats_nxt      = stats_r;
    n_res          = 2'd0;
    r0             = '{kind: swrc_pkg::K_TX_DATA, msg_id: 8'd0, attempt: retries_r};
    r1             = rf_res;
    unique case (swrc_pkg::func_t'(in_func))
      swrc_pkg::FUNC_SEND: begin
        n_res = 2'd1;
        if (in_payload_len > MAX_PAYLOAD || waiting_r) begin
          r0.kind = swrc_pkg::K_REJECT;
        end else begin
          pending_id_nxt = next_id_r;
          next_id_nxt    = next_id_r + 8'd1;
          waiting_nxt    = 1'b1;
          retries_nxt    = 8'd0;
          elapsed_nxt    = 16'd0;
          stats_nxt.sent = stats_r.sent + 32'd1;
          r0             = '{kind: swrc_pkg::K_TX_DATA, msg_id: next_id_r, attempt: 8'd0};
        end
      end
      swrc_pkg::FUNC_TICK: begin
        if (waiting_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_ticks_r) begin
            n_res              = 2'd2;
            stats_nxt.timeouts = stats_r.timeouts + 32'd1;
            r0 = '{kind: swrc_pkg::K_TIMEOUT, msg_id: pending_id_r, attempt: retries_r};
            if (rf_fail) begin
              waiting_nxt = 1'b0;
            end else begin
              retries_nxt       = retries_r + 8'd1;
              stats_nxt.retries = stats_r.retries + 32'd1;
              stats_nxt.sent    = stats_r.sent + 32'd1;
              elapsed_nxt       = 16'd0;
            end
          end
        end
      end
      swrc_pkg::FUNC_RX: begin
        if (in_rx_frame_ok) begin
          unique case (swrc_pkg::rx_kind_t'(in_rx_kind))
            swrc_pkg::RX_DATA: begin
              r0 = '{kind: swrc_pkg::K_TX_ACK, msg_id: in_rx_id, attempt: retries_r};
              r1 = '{kind: swrc_pkg::K_DELIVER, msg_id: in_rx_id, attempt: retries_r};
              n_res = (in_payload_len != 8'd0) ? 2'd2 : 2'd1;
            end
            swrc_pkg::RX_ACK: begin
              if (match) begin
                n_res          = 2'd1;
                waiting_nxt    = 1'b0;
                stats_nxt.acks = stats_r.acks + 32'd1;
                r0 = '{kind: swrc_pkg::K_SUCCESS, msg_id: in_rx_id, attempt: retries_r};
              end
            end
            swrc_pkg::RX_NACK: begin
              if (match) begin
                n_res = 2'd1;
                r0    = rf_res;
                if (rf_fail) begin
                  waiting_nxt = 1'b0;
                end else begin
                  retries_nxt       = retries_r + 8'd1;
                  stats_nxt.retries = stats_r.retries + 32'd1;
                  stats_nxt.sent    = stats_r.sent + 32'd1;
                  elapsed_nxt       = 16'd0;
                end
              end
            end
            default: begin
              n_res = 2'd0;
            end
          endcase
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

  assign push               = accept && (n_res != 2'd0);
  assign push_entry.r0      = r0;
  assign push_entry.r1      = r1;
  assign push_entry.two     = (n_res == 2'd2);
  assign push_entry.pending = waiting_nxt;
  assign push_entry.stats   = stats_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= swrc_pkg::TIMEOUT_RST;
      retry_limit_r   <= swrc_pkg::RETRY_RST;
      next_id_r       <= swrc_pkg::NEXT_ID_RST;
      waiting_r       <= 1'b0;
      pending_id_r    <= 8'd0;
      retries_r       <= 8'd0;
      elapsed_r       <= 16'd0;
      stats_r         <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (swrc_pkg::cfg_idx_t'(cfg_index))
          swrc_pkg::CFG_TIMEOUT: timeout_ticks_r <= cfg_data;
          swrc_pkg::CFG_RETRY:   retry_limit_r   <= cfg_data[7:0];
          default:               retry_limit_r   <= retry_limit_r;
        endcase
      end
      if (accept) begin
        next_id_r    <= next_id_nxt;
        waiting_r    <= waiting_nxt;
        pending_id_r <= pending_id_nxt;
        retries_r    <= retries_nxt;
        elapsed_r    <= elapsed_nxt;
        stats_r      <= stats_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/swrc_queue.sv
// short queue of result entries between front and back
`timescale 1ns / 1ps
`default_nettype none
module swrc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire swrc_pkg::entry_t  push_entry,
  output logic                   full,
  output logic                   q_valid,
  output swrc_pkg::entry_t       q_entry,
  input  wire logic              pop
);

  localparam int Depth = swrc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  swrc_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/swrc_back.sv
// back part: output register that plays out one or two result words per entry
`timescale 1ns / 1ps
`default_nettype none
module swrc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire swrc_pkg::entry_t  q_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_kind,
  output logic [7:0]             out_msg_id,
  output logic [7:0]             out_attempt,
  output logic                   out_pending,
  output logic                   out_last,
  output logic [31:0]            out_sent_count,
  output logic [31:0]            out_timeout_count,
  output logic [31:0]            out_retry_count_total,
  output logic [31:0]            out_ack_count
);

  swrc_pkg::back_state_t state_r, state_nxt;
  swrc_pkg::entry_t      ent_r;
  swrc_pkg::res_t        cur;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swrc_pkg::B_EMPTY: begin
        if (q_valid) state_nxt = swrc_pkg::B_FIRST;
      end
      swrc_pkg::B_FIRST: begin
        if (out_ready) begin
          if (ent_r.two)    state_nxt = swrc_pkg::B_SECOND;
          else if (q_valid) state_nxt = swrc_pkg::B_FIRST;
          else              state_nxt = swrc_pkg::B_EMPTY;
        end
      end
      swrc_pkg::B_SECOND: begin
        if (out_ready) state_nxt = q_valid ? swrc_pkg::B_FIRST : swrc_pkg::B_EMPTY;
      end
      default: state_nxt = swrc_pkg::B_EMPTY;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    cur       = ent_r.r0;
    unique case (state_r)
      swrc_pkg::B_EMPTY: begin
        pop = q_valid;
      end
      swrc_pkg::B_FIRST: begin
        out_valid = 1'b1;
        out_last  = !ent_r.two;
        pop       = q_valid && out_ready && !ent_r.two;
      end
      swrc_pkg::B_SECOND: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        cur       = ent_r.r1;
        pop       = q_valid && out_ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign out_kind              = cur.kind;
  assign out_msg_id            = cur.msg_id;
  assign out_attempt           = cur.attempt;
  assign out_pending           = ent_r.pending;
  assign out_sent_count        = ent_r.stats.sent;
  assign out_timeout_count     = ent_r.stats.timeouts;
  assign out_retry_count_total = ent_r.stats.retries;
  assign out_ack_count         = ent_r.stats.acks;

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swrc_pkg::B_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/stop_and_wait_retry_controller_unit.sv
// top level: stop-and-wait retry controller with front, queue and back parts
//
// input channel (in_*): one word is a send request, a received frame or a time
// tick. the front updates the protocol state and statistics in the cycle the
// word is accepted and queues its results; words that cause no result leave
// nothing in the queue.
// result channel (out_*): one or two words per input word, out_last on the
// final one; each carries the pending flag and counters after that input.
// the results of an accepted input word are written into the queue, then
// loaded into the output register, and shown from there.
// throughput: one input word per cycle while the two-entry queue has
// room; the back side plays out one result word per cycle while out_ready
// is high, so an input with two results occupies the output for both words.
// configuration (cfg_*): index 0 timeout in ticks, index 1 retry limit; always
// ready; written only while the block is idle, which is left to the user.
// reset (rst_n low, synchronous): queue and output emptied, timeout 1000,
// retry limit 3, next id 1, nothing pending, counters cleared.
// stall: when out_ready is low the shown word holds; once the queue is full
// in_ready drops until the receiver takes words again.
`timescale 1ns / 1ps
`default_nettype none
module stop_and_wait_retry_controller_unit #(
  parameter logic [7:0] MAX_PAYLOAD = swrc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_payload_len,
  input  wire logic [1:0]  in_rx_kind,
  input  wire logic [7:0]  in_rx_id,
  input  wire logic        in_rx_frame_ok,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_msg_id,
  output logic [7:0]       out_attempt,
  output logic             out_pending,
  output logic             out_last,
  output logic [31:0]      out_sent_count,
  output logic [31:0]      out_timeout_count,
  output logic [31:0]      out_retry_count_total,
  output logic [31:0]      out_ack_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic             push;
  swrc_pkg::entry_t push_entry;
  logic             full;
  logic             q_valid;
  swrc_pkg::entry_t q_entry;
  logic             pop;

  assign in_ready  = !full;
  assign cfg_ready = 1'b1;

  swrc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_payload_len (in_payload_len),
    .in_rx_kind     (in_rx_kind),
    .in_rx_id       (in_rx_id),
    .in_rx_frame_ok (in_rx_frame_ok),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .push_entry     (push_entry)
  );

  swrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  swrc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_entry               (q_entry),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_msg_id            (out_msg_id),
    .out_attempt           (out_attempt),
    .out_pending           (out_pending),
    .out_last              (out_last),
    .out_sent_count        (out_sent_count),
    .out_timeout_count     (out_timeout_count),
    .out_retry_count_total (out_retry_count_total),
    .out_ack_count         (out_ack_count)
  );

endmodule
`default_nettype wire

### rtl/swrc_checker.sv
// checker: port-level assertions for the stop-and-wait retry controller
`timescale 1ns / 1ps
`default_nettype none
module swrc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_msg_id,
  input wire logic       out_pending,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_msg_id))
    else $error("result word changed while stalled");

  a_timeout_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == swrc_pkg::K_TIMEOUT |-> !out_last)
    else $error("timeout notice must be followed by retry or failure");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == swrc_pkg::K_REJECT |-> out_msg_id == 8'd0 && out_last)
    else $error("rejected send has wrong form");

  a_done_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == swrc_pkg::K_SUCCESS || out_kind == swrc_pkg::K_FAILED)
    |-> !out_pending)
    else $error("finished send still pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind stop_and_wait_retry_controller_unit swrc_checker u_swrc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_msg_id  (out_msg_id),
  .out_pending (out_pending),
  .out_last    (out_last)
);
`default_nettype wire

### tb/sv/swrc_link_checker.sv
// checker: stop-and-wait link predictor and result word comparison
`timescale 1ns / 1ps
module swrc_link_checker
  import swrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_payload_len,
  input  logic [1:0]  in_rx_kind,
  input  logic [7:0]  in_rx_id,
  input  logic        in_rx_frame_ok,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_msg_id,
  input  logic [7:0]  out_attempt,
  input  logic        out_pending,
  input  logic        out_last,
  input  logic [31:0] out_sent_count,
  input  logic [31:0] out_timeout_count,
  input  logic [31:0] out_retry_count_total,
  input  logic [31:0] out_ack_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          open_words,
  output logic [7:0]  link_id
);

  typedef struct packed {
    res_t   res;
    logic   pending;
    logic   last;
    stats_t stats;
  } link_word_t;

  logic [15:0] tmo_ticks;
  logic [7:0]  retry_max;
  logic [7:0]  next_id;
  logic        busy;
  logic [7:0]  pend_id;
  logic [7:0]  tries;
  logic [15:0] waited;
  stats_t      tally;
  int          errors = 0;
  link_word_t  due_words[$];

  function automatic res_t resend_or_give_up();
    res_t r;
    if (tries >= retry_max) begin
      busy = 1'b0;
      r = '{K_FAILED, pend_id, tries};
    end else begin
      tries = tries + 8'd1;
      tally.retries = tally.retries + 32'd1;
      tally.sent = tally.sent + 32'd1;
      waited = 16'd0;
      r = '{K_TX_DATA, pend_id, tries};
    end
    return r;
  endfunction

  task automatic advance_link(input func_t f, input logic [7:0] plen, input rx_kind_t rk,
                              input logic [7:0] rid, input logic rok);
    res_t       r [2];
    int         n;
    logic       hit;
    link_word_t w;
    n = 0;
    hit = busy && (rid == pend_id);
    case (f)
      FUNC_SEND: begin
        if (plen > MAX_PAYLOAD_DEF || busy) begin
          r[0] = '{K_REJECT, 8'd0, tries};
          n = 1;
        end else begin
          pend_id = next_id;
          next_id = next_id + 8'd1;
          busy = 1'b1;
          tries = 8'd0;
          waited = 16'd0;
          tally.sent = tally.sent + 32'd1;
          r[0] = '{K_TX_DATA, pend_id, 8'd0};
          n = 1;
        end
      end
      FUNC_TICK: begin
        if (busy) begin
          if (waited != 16'hFFFF) waited = waited + 16'd1;
          if (waited >= tmo_ticks) begin
            tally.timeouts = tally.timeouts + 32'd1;
            r[0] = '{K_TIMEOUT, pend_id, tries};
            r[1] = resend_or_give_up();
            n = 2;
          end
        end
      end
      FUNC_RX: begin
        if (rok) begin
          if (rk == RX_DATA) begin
            r[0] = '{K_TX_ACK, rid, tries};
            n = 1;
            if (plen != 8'd0) begin
              r[1] = '{K_DELIVER, rid, tries};
              n = 2;
            end
          end else if (rk == RX_ACK && hit) begin
            busy = 1'b0;
            tally.acks = tally.acks + 32'd1;
            r[0] = '{K_SUCCESS, rid, tries};
            n = 1;
          end else if (rk == RX_NACK && hit) begin
            r[0] = resend_or_give_up();
            n = 1;
          end
        end
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      w.res = r[k];
      w.pending = busy;
      w.last = (k == n - 1);
      w.stats = tally;
      due_words.push_back(w);
    end
  endtask

  function automatic void field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic match_word();
    link_word_t want;
    if (due_words.size() == 0) begin
      $display("%0t: word with nothing expected, actual kind %0d id %0d", $time, out_kind,
               out_msg_id);
      errors++;
    end else begin
      want = due_words.pop_front();
      field_diff("kind", 32'(want.res.kind), 32'(out_kind));
      field_diff("msg_id", 32'(want.res.msg_id), 32'(out_msg_id));
      field_diff("attempt", 32'(want.res.attempt), 32'(out_attempt));
      field_diff("pending", 32'(want.pending), 32'(out_pending));
      field_diff("last", 32'(want.last), 32'(out_last));
      field_diff("sent_count", want.stats.sent, out_sent_count);
      field_diff("timeout_count", want.stats.timeouts, out_timeout_count);
      field_diff("retry_count_total", want.stats.retries, out_retry_count_total);
      field_diff("ack_count", want.stats.acks, out_ack_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tmo_ticks = TIMEOUT_RST;
      retry_max = RETRY_RST;
      next_id = NEXT_ID_RST;
      busy = 1'b0;
      pend_id = 8'd0;
      tries = 8'd0;
      waited = 16'd0;
      tally = '0;
      due_words.delete();
    end else begin
      if (out_valid && out_ready) match_word();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIMEOUT) tmo_ticks = cfg_data;
        else retry_max = cfg_data[7:0];
      end
      if (in_valid && in_ready)
        advance_link(func_t'(in_func), in_payload_len, rx_kind_t'(in_rx_kind), in_rx_id,
                     in_rx_frame_ok);
    end
    fail_count <= errors;
    open_words <= due_words.size();
    link_id <= pend_id;
  end

endmodule

### tb/sv/stop_and_wait_retry_controller_unit_tb.sv
// testbench top: stimulus, idling and verdict for the stop-and-wait retry controller
`timescale 1ns / 1ps
module stop_and_wait_retry_controller_unit_tb;
  import swrc_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = 2'd0;
  logic [7:0]  in_payload_len = 8'd0;
  logic [1:0]  in_rx_kind = 2'd0;
  logic [7:0]  in_rx_id = 8'd0;
  logic        in_rx_frame_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_msg_id;
  logic [7:0]  out_attempt;
  logic        out_pending;
  logic        out_last;
  logic [31:0] out_sent_count;
  logic [31:0] out_timeout_count;
  logic [31:0] out_retry_count_total;
  logic [31:0] out_ack_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  int          fail_count;
  int          open_words;
  logic [7:0]  link_id;
  logic        quiet = 1'b0;
  int          items = 0;

  stop_and_wait_retry_controller_unit u_dut (.*);
  swrc_link_checker u_chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) out_ready <= quiet || ($urandom_range(99) >= 23);

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic push_word(input func_t f, input logic [7:0] plen, input rx_kind_t rk,
                           input logic [7:0] rid, input logic rok);
    if (!quiet) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_payload_len <= plen;
    in_rx_kind <= rk;
    in_rx_id <= rid;
    in_rx_frame_ok <= rok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every expected word, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_tick();
    push_word(FUNC_TICK, 8'($urandom), rx_kind_t'($urandom_range(3)), 8'($urandom),
              1'($urandom));
  endtask

  task automatic push_noise();
    push_word(func_t'($urandom_range(3)), 8'($urandom), rx_kind_t'($urandom_range(3)),
              ($urandom_range(3) == 0) ? link_id : 8'($urandom), 1'($urandom));
  endtask

  task automatic push_filler();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) push_tick();
    else if (pick < 85)
      push_word(FUNC_RX, ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom), RX_DATA,
                8'($urandom), $urandom_range(9) != 0);
    else push_noise();
  endtask

  // one send with its traffic: ticks, frames, nacks, then an ack or more ticks
  task automatic run_exchange();
    push_word(FUNC_SEND,
              ($urandom_range(9) == 0) ? 8'($urandom_range(255, 241)) : 8'($urandom_range(240)),
              rx_kind_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
    repeat ($urandom_range(2, 1)) push_filler();
    repeat ($urandom_range(2)) push_word(FUNC_RX, 8'($urandom), RX_NACK, link_id, 1'b1);
    if ($urandom_range(99) < 70) push_word(FUNC_RX, 8'($urandom), RX_ACK, link_id, 1'b1);
    else repeat ($urandom_range(6)) push_tick();
  endtask

  initial begin
    int retune_at;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings
    push_word(FUNC_SEND, 8'd0, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_TICK, 8'd0, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_RX, 8'd0, RX_ACK, 8'd1, 1'b1);
    settle();

    write_reg(CFG_TIMEOUT, 16'd3);
    write_reg(CFG_RETRY, 16'd2);
    push_word(FUNC_SEND, 8'd0, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_SEND, 8'd240, RX_DATA, 8'd0, 1'b0);
    repeat (3) push_word(FUNC_TICK, 8'd0, RX_DATA, 8'd0, 1'b0);
    repeat (2) push_word(FUNC_RX, 8'd0, RX_NACK, 8'd2, 1'b1);
    push_word(FUNC_SEND, 8'd241, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_SEND, 8'd240, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_RX, 8'd0, RX_ACK, 8'd4, 1'b1);
    push_word(FUNC_RX, 8'd0, RX_ACK, 8'd3, 1'b0);
    push_word(FUNC_RX, 8'd0, RX_UNKNOWN, 8'd3, 1'b1);
    push_word(FUNC_RX, 8'd0, RX_ACK, 8'd3, 1'b1);
    push_word(FUNC_RX, 8'd0, RX_ACK, 8'd3, 1'b1);
    push_word(FUNC_TICK, 8'd0, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_RX, 8'd0, RX_DATA, 8'd0, 1'b1);
    push_word(FUNC_RX, 8'd255, RX_DATA, 8'd255, 1'b1);
    push_word(FUNC_NONE, 8'd255, RX_UNKNOWN, 8'd255, 1'b1);
    push_word(FUNC_SEND, 8'd1, RX_DATA, 8'd0, 1'b0);
    push_word(FUNC_RX, 8'd0, RX_NACK, 8'd4, 1'b1);
    repeat (6) push_word(FUNC_TICK, 8'd0, RX_DATA, 8'd0, 1'b0);
    settle();

    // no idling on either side
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_RETRY, 16'd0);
    quiet <= 1'b1;
    repeat (30) run_exchange();
    quiet <= 1'b0;
    settle();

    // retransmit up to the largest retry limit, then fail
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_RETRY, 16'd255);
    push_word(FUNC_SEND, 8'd17, RX_DATA, 8'd0, 1'b0);
    push_tick();
    repeat (256) push_word(FUNC_RX, 8'($urandom), RX_NACK, link_id, 1'b1);
    repeat (8) run_exchange();
    settle();

    retune_at = items;
    while (items < 550) begin
      if (items >= retune_at) begin
        settle();
        write_reg(CFG_TIMEOUT, 16'($urandom_range(8)));
        write_reg(CFG_RETRY, 16'($urandom_range(4)));
        retune_at = retune_at + 40;
      end
      if ($urandom_range(99) < 85) run_exchange();
      else push_noise();
    end
    settle();

    if (fail_count == 0 && open_words == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
